// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define STT_ASSERT(lbl, clk, rst_n, prop, msg)

`define STT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/stt_pkg.sv -----
package stt_pkg;

    localparam int SLOTS = 64;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int KEY_W = 32;
    localparam int TMR_W = 24;
    localparam logic [TMR_W-1:0] TIMEOUT_RESET = 24'd30000;

    localparam int IN_W  = 72;
    localparam int OUT_W = 80;

    typedef enum logic [1:0] {
        FN_REG   = 2'd0,
        FN_UNREG = 2'd1,
        FN_TICK  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_NOEXP    = 2'd3
    } t_status;

    typedef struct packed {
        t_func             func;
        logic [KEY_W-1:0]  tkey;
        logic [KEY_W-1:0]  skey;
        logic [TMR_W-1:0]  timeout;
    } t_cmd;

    // search token walking the slot chain
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  thread;
        logic [KEY_W-1:0]  socket;
    } t_link;

endpackage

// ----- rtl/stt_cell.sv -----
module stt_cell
    import stt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_dec,
    input  logic [IDX_W-1:0] i_idx,
    input  t_link            i_link,
    output t_link            o_link
);

    logic             r_valid;
    logic [KEY_W-1:0] r_thread;
    logic [KEY_W-1:0] r_socket;
    logic [TMR_W-1:0] r_timer;
    t_link            r_link;

    logic  w_cond;
    logic  w_take;
    t_link n_link;

    always_comb begin
        case (i_cmd.func)
            FN_REG:   w_cond = !r_valid;
            FN_UNREG: w_cond = r_valid && (r_thread == i_cmd.tkey);
            FN_TICK:  w_cond = r_valid && (r_timer == '0);
            default:  w_cond = 1'b0;
        endcase
    end

    assign w_take = i_link.valid && !i_link.hit && w_cond;

    always_comb begin
        n_link = i_link;
        if (w_take) begin
            n_link.hit = 1'b1;
            n_link.idx = i_idx;
            if (i_cmd.func == FN_TICK) begin
                n_link.thread = r_thread;
                n_link.socket = r_socket;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_link  <= '0;
        end else begin
            r_link <= n_link;
            if (w_take) begin
                r_valid <= (i_cmd.func == FN_REG);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && (i_cmd.func == FN_REG)) begin
            r_thread <= i_cmd.tkey;
            r_socket <= i_cmd.skey;
            r_timer  <= i_cmd.timeout;
        end else if (i_dec && (i_cmd.func == FN_TICK) && r_valid && (r_timer != '0)) begin
            r_timer <= r_timer - 1'b1;
        end
    end

    assign o_link = r_link;

endmodule

// ----- rtl/session_timeout_table_core.sv -----
// channel      direction  signals                 beat contents
// s_axis       in         tvalid tready tdata     func, thread_key, socket_key
// m_axis       out        tvalid tready tdata     status, slot_index, expired_thread,
//                                                 expired_socket, active_count
// cfg          in         i_cfg_we i_cfg_wdata    timeout_ticks
//
// one beat at a time: the result is registered once the search token has stepped one
// slot cell per cycle along the chain to its end
// a tick beat first decrements, in the S_DEC state, every live nonzero timer in parallel
// the next input beat is taken once the result sits in the output register
// a stalled m_axis holds the result and blocks the next search from finishing
// reset frees every slot, zeroes the count and loads timeout_ticks with 30000
`include "assert_macros.svh"

module session_timeout_table_core
    import stt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // func[1:0] thread_key[33:2] socket_key[65:34]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_W-1:0]  m_axis_tdata,   // status[1:0] slot_index[7:2]
                                              // expired_thread[39:8] expired_socket[71:40]
                                              // active_count[78:72]
    input  logic              i_cfg_we,
    input  logic [TMR_W-1:0]  i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DEC  = 4'b0010,
        S_SCAN = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    logic [TMR_W-1:0]  r_timeout;
    logic              r_inj;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        r_res_status;
    logic [IDX_W-1:0]  r_res_idx;
    logic [KEY_W-1:0]  r_res_thread;
    logic [KEY_W-1:0]  r_res_socket;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic [1:0]        n_status;

    t_link             w_link [SLOTS+1];
    t_link             w_last;
    logic              w_accept;
    logic              w_load;
    logic [IDX_W+5:0]  w_idx_ext;
    logic [CNT_W+6:0]  w_cnt_ext;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last        = w_link[SLOTS];
    assign w_load        = (r_state == S_HOLD) && (!r_out_valid || m_axis_tready);

    assign w_link[0] = '{valid: r_inj, hit: 1'b0, idx: '0, thread: '0, socket: '0};

    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        stt_cell u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (r_cmd),
            .i_dec   (r_state == S_DEC),
            .i_idx   (IDX_W'(g)),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_DEC;
            S_DEC:   n_state = S_SCAN;
            S_SCAN:  if (w_last.valid) n_state = S_HOLD;
            S_HOLD:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_last.hit) begin
            if (r_cmd.func == FN_REG) begin
                n_count = r_count + 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_comb begin
        if (w_last.hit) begin
            n_status = ST_DONE;
        end else begin
            case (r_cmd.func)
                FN_REG:   n_status = ST_FULL;
                FN_UNREG: n_status = ST_NOTFOUND;
                default:  n_status = ST_NOEXP;
            endcase
        end
    end

    assign w_idx_ext = {6'd0, r_res_idx};
    assign w_cnt_ext = {7'd0, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= TIMEOUT_RESET;
            r_inj       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= (r_state == S_DEC);
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if ((r_state == S_SCAN) && w_last.valid) begin
                r_count <= n_count;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.func    <= t_func'(s_axis_tdata[1:0]);
            r_cmd.tkey    <= s_axis_tdata[33:2];
            r_cmd.skey    <= s_axis_tdata[65:34];
            r_cmd.timeout <= r_timeout;
        end
        if ((r_state == S_SCAN) && w_last.valid) begin
            r_res_status <= n_status;
            r_res_idx    <= w_last.idx;
            r_res_thread <= w_last.thread;
            r_res_socket <= w_last.socket;
        end
        if (w_load) begin
            r_out_data <= {1'b0, w_cnt_ext[6:0], r_res_socket, r_res_thread,
                           w_idx_ext[5:0], r_res_status};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `STT_ASSERT(a_accept_starts, i_clk, i_rst_n, w_accept |=> (r_state == S_DEC), "accept did not start an item")
    `STT_ASSERT(a_token_in_scan, i_clk, i_rst_n, w_last.valid |-> (r_state == S_SCAN), "token left chain outside scan")
    `STT_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(SLOTS), "occupied count above table size")
    `STT_ASSERT(a_reg_room, i_clk, i_rst_n, (w_last.hit && (r_cmd.func == FN_REG)) |-> (r_count < CNT_W'(SLOTS)), "register hit on a full table")
    `STT_ASSERT(a_free_nonempty, i_clk, i_rst_n, (w_last.hit && (r_cmd.func != FN_REG)) |-> (r_count != '0), "slot freed with zero count")

endmodule
